[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// Task scheduler table package
// Sizes, operation and status codes, slot record and sequencer state types
// shared by the scheduler table modules.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int NUM_SLOTS    = 8;
   localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int RESULT_LIMIT = 8;
   localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

   // slot_out code for "no slot", masked to the 4-bit field
   localparam logic [3:0] SLOT_NONE = 4'(NUM_SLOTS);

   typedef enum logic [1:0] {
      OP_ADD,
      OP_DELETE,
      OP_TICK,
      OP_DISPATCH
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_BAD_INDEX,
      STAT_NOTHING
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  tag;
      logic [31:0] delay;
      logic [31:0] period;
      logic [7:0]  runs;
   } slot_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  tag;
      logic [31:0] delay;
      logic [31:0] period;
   } cmd_type;

endpackage

[rtl/tts_req_if.sv]
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one scheduler operation per transaction.
// ----------------------------------------------------------------------------
interface tts_req_if;
   import tts_pkg::*;

   logic        valid;
   logic        ready;
   op_type      op;
   logic [7:0]  task_tag;
   logic [31:0] first_delay;
   logic [31:0] repeat_period;
   logic [7:0]  slot_index;

   modport source (
      output valid, op, task_tag, first_delay, repeat_period, slot_index,
      input  ready
   );

   modport sink (
      input  valid, op, task_tag, first_delay, repeat_period, slot_index,
      output ready
   );

endinterface

[rtl/tts_rsp_if.sv]
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying one scheduler result per transaction.
// ----------------------------------------------------------------------------
interface tts_rsp_if;
   import tts_pkg::*;

   logic       valid;
   logic       ready;
   logic [3:0] slot_out;
   logic [7:0] tag_out;
   status_type status;
   logic       last;

   modport source (
      output valid, slot_out, tag_out, status, last,
      input  ready
   );

   modport sink (
      input  valid, slot_out, tag_out, status, last,
      output ready
   );

endinterface

[rtl/tts_slot_alu.sv]
// ----------------------------------------------------------------------------
// Scheduler slot update unit
// Computes the new contents of one slot for the current operation and flags
// whether the slot is a match (free for add, always for delete, active for
// tick, pending for dispatch).
// ----------------------------------------------------------------------------
module tts_slot_alu (
   input  tts_pkg::cmd_type  cmd,
   input  tts_pkg::slot_type cur,
   output tts_pkg::slot_type nxt,
   output logic              hit
);
   import tts_pkg::*;

   always_comb begin
      nxt = cur;
      hit = 1'b0;
      case (cmd.op)
         OP_ADD: begin
            hit        = !cur.valid;
            nxt.valid  = 1'b1;
            nxt.tag    = cmd.tag;
            nxt.delay  = cmd.delay;
            nxt.period = cmd.period;
            nxt.runs   = 8'd0;
         end
         OP_DELETE: begin
            hit = 1'b1;
            nxt = '0;
         end
         OP_TICK: begin
            hit = cur.valid;
            if (cur.valid) begin
               if (cur.delay == 32'd0) begin
                  if (cur.runs != 8'hFF) nxt.runs = cur.runs + 8'd1;
                  if (cur.period != 32'd0) nxt.delay = cur.period;
               end else begin
                  nxt.delay = cur.delay - 32'd1;
               end
            end
         end
         OP_DISPATCH: begin
            hit = (cur.runs != 8'd0);
            if (hit) begin
               nxt.runs = cur.runs - 8'd1;
               // one-shot task is freed once it has run
               if (cur.period == 32'd0) nxt = '0;
            end
         end
         default: begin
            nxt = cur;
            hit = 1'b0;
         end
      endcase
   end

endmodule

[rtl/tick_task_scheduler_table_core.sv]
// ----------------------------------------------------------------------------
// Tick task scheduler table
// Table of timed task slots with add, delete, tick and dispatch operations,
// walked one slot per cycle (unless a dispatch stalls) by a small sequencer and a shared update unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one operation per transaction (add, delete, tick,
//   dispatch); rsp_chan returns its results, the final one marked by last.
//   Add, delete and tick give one result; dispatch gives one result per
//   pending slot in slot order (at most RESULT_LIMIT), or a single
//   "nothing to run" result.
//   Timing: the sequencer visits one slot per cycle through the update unit, except while a dispatch stalls.
//   Delete visits only the indexed slot, add scans to the first free slot,
//   tick visits every slot, dispatch every slot or up to RESULT_LIMIT hits;
//   each then hands its final result to the output register in a finish state.
//   req_chan.ready is high only while the sequencer is idle.
//   The output register frees the sequencer: the next operation may start
//   while the last result is still waiting. If rsp_chan stalls, a dispatch
//   holds at the next pending slot and the final result waits in place.
//   Reset (synchronous) empties every slot and drops any waiting result.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_core (
   input  logic  clock,
   input  logic  reset,
   tts_req_if.sink   req_chan,
   tts_rsp_if.source rsp_chan
);
   import tts_pkg::*;

   function automatic logic [3:0] slot_code(input logic [SLOT_W-1:0] s);
      return 4'(s);
   endfunction

   // slot storage
   logic        slot_valid_ff  [NUM_SLOTS];
   logic [7:0]  slot_tag_ff    [NUM_SLOTS];
   logic [31:0] slot_delay_ff  [NUM_SLOTS];
   logic [31:0] slot_period_ff [NUM_SLOTS];
   logic [7:0]  slot_runs_ff   [NUM_SLOTS];

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [7:0]       idx_ff, idx_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [3:0]       pend_slot_ff, pend_slot_in;
   logic [7:0]       pend_tag_ff, pend_tag_in;
   status_type       pend_stat_ff, pend_stat_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic [7:0]       rsp_tag_ff, rsp_tag_in;
   status_type       rsp_stat_ff, rsp_stat_in;
   logic             rsp_last_ff, rsp_last_in;

   slot_type cur_slot;
   slot_type slot_in;
   logic     hit;
   logic     wr_en;
   logic     last_slot;
   logic     in_range;
   logic     out_free;
   logic     stall;
   logic     scan_done;
   logic     req_fire;

   assign cur_slot = '{valid:  slot_valid_ff[ptr_ff],
                       tag:    slot_tag_ff[ptr_ff],
                       delay:  slot_delay_ff[ptr_ff],
                       period: slot_period_ff[ptr_ff],
                       runs:   slot_runs_ff[ptr_ff]};

   tts_slot_alu u_alu (
      .cmd (cmd_ff),
      .cur (cur_slot),
      .nxt (slot_in),
      .hit (hit)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign last_slot = (ptr_ff == SLOT_W'(NUM_SLOTS - 1));
   assign in_range  = (idx_ff < 8'(NUM_SLOTS));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   // a new pending slot can only be taken once the previous one is pushed out
   assign stall     = (cmd_ff.op == OP_DISPATCH) && hit && pend_valid_ff && !out_free;

   always_comb begin
      case (cmd_ff.op)
         OP_ADD:      scan_done = hit || last_slot;
         OP_DELETE:   scan_done = 1'b1;
         OP_TICK:     scan_done = last_slot;
         OP_DISPATCH: scan_done = last_slot ||
                                  (hit && (cnt_ff + CNT_W'(1) == CNT_W'(RESULT_LIMIT)));
         default:     scan_done = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_SCAN;
         ST_SCAN:   if (!stall && scan_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic out_load;
      logic out_last;

      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      pend_stat_in  = pend_stat_ff;
      wr_en         = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in.op     = req_chan.op;
               cmd_in.tag    = req_chan.task_tag;
               cmd_in.delay  = req_chan.first_delay;
               cmd_in.period = req_chan.repeat_period;
               idx_in        = req_chan.slot_index;
               ptr_in        = (req_chan.op == OP_DELETE) ?
                               req_chan.slot_index[SLOT_W-1:0] : '0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               case (cmd_ff.op)
                  OP_ADD: begin
                     wr_en = hit;
                     if (hit) begin
                        pend_slot_in = slot_code(ptr_ff);
                        pend_tag_in  = 8'd0;
                        pend_stat_in = STAT_OK;
                     end else if (last_slot) begin
                        pend_slot_in = SLOT_NONE;
                        pend_tag_in  = 8'd0;
                        pend_stat_in = STAT_FULL;
                     end
                  end
                  OP_DELETE: begin
                     wr_en        = in_range;
                     pend_slot_in = in_range ? slot_code(ptr_ff) : SLOT_NONE;
                     pend_tag_in  = 8'd0;
                     pend_stat_in = in_range ? STAT_OK : STAT_BAD_INDEX;
                  end
                  OP_TICK: begin
                     wr_en        = 1'b1;
                     pend_slot_in = SLOT_NONE;
                     pend_tag_in  = 8'd0;
                     pend_stat_in = STAT_OK;
                  end
                  OP_DISPATCH: begin
                     wr_en = hit;
                     if (hit) begin
                        out_load      = pend_valid_ff;
                        pend_valid_in = 1'b1;
                        pend_slot_in  = slot_code(ptr_ff);
                        pend_tag_in   = cur_slot.tag;
                        pend_stat_in  = STAT_OK;
                        cnt_in        = cnt_ff + CNT_W'(1);
                     end else if (scan_done && !pend_valid_ff) begin
                        pend_slot_in = SLOT_NONE;
                        pend_tag_in  = 8'd0;
                        pend_stat_in = STAT_NOTHING;
                     end
                  end
                  default: wr_en = 1'b0;
               endcase
               if (!scan_done) ptr_in = ptr_ff + SLOT_W'(1);
            end
         end
         ST_FINISH: begin
            out_load = out_free;
            out_last = 1'b1;
         end
         default: out_load = 1'b0;
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = pend_slot_ff;
         rsp_tag_in   = pend_tag_ff;
         rsp_stat_in  = pend_stat_ff;
         rsp_last_in  = out_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         ptr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      pend_stat_ff <= pend_stat_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // valid marks and run counts decide every visible result, so reset clears them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
            slot_runs_ff[i]  <= 8'd0;
         end
      end else if (wr_en) begin
         slot_valid_ff[ptr_ff] <= slot_in.valid;
         slot_runs_ff[ptr_ff]  <= slot_in.runs;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_tag_ff[ptr_ff]    <= slot_in.tag;
         slot_delay_ff[ptr_ff]  <= slot_in.delay;
         slot_period_ff[ptr_ff] <= slot_in.period;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.slot_out = rsp_slot_ff;
   assign rsp_chan.tag_out  = rsp_tag_ff;
   assign rsp_chan.status   = rsp_stat_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // final result always lands in the output register as the sequencer goes idle
   a_finish_emits_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final result not loaded on finish");

   // only dispatch produces intermediate results
   a_mid_only_dispatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (cmd_ff.op == OP_DISPATCH))
      else $error("non-final result outside dispatch");

   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RESULT_LIMIT))
      else $error("dispatch result count over limit");

   a_nothing_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff == STAT_NOTHING) |->
         (rsp_last_ff && rsp_tag_ff == 8'd0 && rsp_slot_ff == SLOT_NONE))
      else $error("malformed nothing-to-run result");

   // no slot is written while a dispatch is held by a stalled receiver
   a_stall_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stall) |-> !wr_en)
      else $error("slot written during dispatch stall");

endmodule

[tb/tick_task_scheduler_table_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick task scheduler table testbench
// Drives add, delete, tick and dispatch operations with random gaps on the
// request side and random stalls on the response side. A scoreboard keeps
// its own copy of the slot table and checks every result in order.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table_core_tb;
   import tts_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_ITEMS = 24;
   localparam int SAT_TICKS    = 258;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [3:0] slot;
      logic [7:0] tag;
      status_type status;
      logic       last;
   } sched_result_type;

   class table_scoreboard;
      slot_type         slots[NUM_SLOTS];
      sched_result_type due_results[$];
      int               errors;

      function new();
         foreach (slots[s]) slots[s] = '0;
         errors = 0;
      endfunction

      function int free_slots();
         int n;
         n = 0;
         foreach (slots[s]) if (!slots[s].valid) n++;
         return n;
      endfunction

      function void push_result(logic [3:0] slot, logic [7:0] tag, status_type status,
                                logic last);
         sched_result_type r;
         r.slot   = slot;
         r.tag    = tag;
         r.status = status;
         r.last   = last;
         due_results.push_back(r);
      endfunction

      // Predict the results of one accepted operation and update the table
      function void note_request(op_type op, logic [7:0] tag, logic [31:0] delay,
                                 logic [31:0] period, logic [7:0] index);
         int               n;
         bit               placed;
         sched_result_type r;
         n      = 0;
         placed = 0;
         case (op)
            OP_ADD: begin
               for (int s = 0; s < NUM_SLOTS && !placed; s++) begin
                  if (!slots[s].valid) begin
                     slots[s].valid  = 1'b1;
                     slots[s].tag    = tag;
                     slots[s].delay  = delay;
                     slots[s].period = period;
                     slots[s].runs   = '0;
                     push_result(4'(s), 8'h00, STAT_OK, 1'b1);
                     placed = 1;
                  end
               end
               if (!placed) push_result(SLOT_NONE, 8'h00, STAT_FULL, 1'b1);
            end
            OP_DELETE: begin
               if (index < NUM_SLOTS) begin
                  slots[index] = '0;
                  push_result(4'(index), 8'h00, STAT_OK, 1'b1);
               end else begin
                  push_result(SLOT_NONE, 8'h00, STAT_BAD_INDEX, 1'b1);
               end
            end
            OP_TICK: begin
               foreach (slots[s]) begin
                  if (slots[s].valid) begin
                     if (slots[s].delay == 0) begin
                        if (slots[s].runs != 8'hFF) slots[s].runs++;
                        if (slots[s].period != 0) slots[s].delay = slots[s].period;
                     end else begin
                        slots[s].delay--;
                     end
                  end
               end
               push_result(SLOT_NONE, 8'h00, STAT_OK, 1'b1);
            end
            default: begin
               for (int s = 0; s < NUM_SLOTS && n < RESULT_LIMIT; s++) begin
                  if (slots[s].runs != 0) begin
                     slots[s].runs--;
                     push_result(4'(s), slots[s].tag, STAT_OK, 1'b0);
                     n++;
                     if (slots[s].period == 0) slots[s] = '0;
                  end
               end
               if (n == 0) begin
                  push_result(SLOT_NONE, 8'h00, STAT_NOTHING, 1'b1);
               end else begin
                  r = due_results.pop_back();
                  r.last = 1'b1;
                  due_results.push_back(r);
               end
            end
         endcase
      endfunction

      function void check_result(logic [3:0] slot, logic [7:0] tag, status_type status,
                                 logic last);
         sched_result_type r;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: unexpected result slot=%0d tag=%0h status=%0d last=%0b",
                        slot, tag, status, last);
            return;
         end
         r = due_results.pop_front();
         if (r.slot !== slot || r.tag !== tag || r.status !== status || r.last !== last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"ERROR: result mismatch exp slot=%0d tag=%0h status=%0d last=%0b,",
                         " got slot=%0d tag=%0h status=%0d last=%0b"},
                        r.slot, r.tag, r.status, r.last, slot, tag, status, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet_mode;
   int   idle_cycles;
   int   stall_left;

   table_scoreboard sched;

   tts_req_if req_if();
   tts_rsp_if rsp_if();

   tick_task_scheduler_table_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // response side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sched.check_result(rsp_if.slot_out, rsp_if.tag_out, rsp_if.status, rsp_if.last);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tick_task_scheduler_table_core test failed");
      $finish;
   end

   task automatic issue_op(op_type op, logic [7:0] tag, logic [31:0] delay,
                           logic [31:0] period, logic [7:0] index);
      int gap;
      gap = quiet_mode ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid         <= 1'b1;
      req_if.op            <= op;
      req_if.task_tag      <= tag;
      req_if.first_delay   <= delay;
      req_if.repeat_period <= period;
      req_if.slot_index    <= index;
      do @(posedge clock); while (!req_if.ready);
      sched.note_request(op, tag, delay, period, index);
   endtask

   initial begin
      op_type      op;
      logic [7:0]  tag;
      logic [31:0] delay;
      logic [31:0] period;
      logic [7:0]  index;
      int          r;

      sched                = new();
      quiet_mode           = 0;
      stall_left           = 0;
      idle_cycles          = 0;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.op            = OP_ADD;
      req_if.task_tag      = '0;
      req_if.first_delay   = '0;
      req_if.repeat_period = '0;
      req_if.slot_index    = '0;
      rsp_if.ready         = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, delete of a free slot and out-of-range indexes
      issue_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_TICK,     8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DELETE,   8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DELETE,   8'h00, 32'h0, 32'h0, 8'(NUM_SLOTS));
      issue_op(OP_DELETE,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      // one-shot tag 0, extreme delay and period, short periodic
      issue_op(OP_ADD,      8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_ADD,      8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
      issue_op(OP_ADD,      8'hA5, 32'd1, 32'd2, 8'd0);
      issue_op(OP_TICK,     8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_TICK,     8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 8'd0);
      // fill the table, then overflow it
      for (int i = 0; i < NUM_SLOTS - 2; i++)
         issue_op(OP_ADD, 8'(8'h10 + i), 32'h0, 32'(i % 2), 8'd0);
      issue_op(OP_ADD,      8'h77, 32'h0, 32'h0, 8'd0);
      issue_op(OP_TICK,     8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DELETE,   8'h00, 32'h0, 32'h0, 8'(NUM_SLOTS - 1));
      issue_op(OP_ADD,      8'h3C, 32'h0, 32'hFFFF_FFFF, 8'd0);
      issue_op(OP_DELETE,   8'h00, 32'h0, 32'h0, 8'd1);

      // run-count saturation on a lone one-shot slot
      for (int i = 0; i < NUM_SLOTS; i++)
         issue_op(OP_DELETE, 8'h00, 32'h0, 32'h0, 8'(i));
      issue_op(OP_ADD, 8'hC3, 32'h0, 32'h0, 8'd0);
      for (int i = 0; i < SAT_TICKS; i++)
         issue_op(OP_TICK, 8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 8'd0);
      issue_op(OP_DISPATCH, 8'h00, 32'h0, 32'h0, 8'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 8 == 0) quiet_mode = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (sched.free_slots() > 0)
            op = (r < 30) ? OP_ADD : (r < 42) ? OP_DELETE : (r < 80) ? OP_TICK : OP_DISPATCH;
         else
            op = (r < 5) ? OP_ADD : (r < 30) ? OP_DELETE : (r < 70) ? OP_TICK : OP_DISPATCH;
         tag = 8'($urandom);
         r = $urandom_range(0, 99);
         delay = (r < 70) ? 32'($urandom_range(0, 3)) :
                 (r < 85) ? 32'($urandom_range(4, 20)) : 32'($urandom);
         r = $urandom_range(0, 99);
         period = (r < 30) ? 32'h0 : (r < 85) ? 32'($urandom_range(1, 4)) : 32'($urandom);
         index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_SLOTS, 255)) :
                                                8'($urandom_range(0, NUM_SLOTS - 1));
         issue_op(op, tag, delay, period, index);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sched.due_results.size() != 0) @(posedge clock);
      repeat (4 * NUM_SLOTS) @(posedge clock);
      if (sched.errors == 0 && sched.due_results.size() == 0) begin
         $display("tick_task_scheduler_table_core test passed");
      end else begin
         $display("tick_task_scheduler_table_core test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tts_pkg.sv
rtl/tts_req_if.sv
rtl/tts_rsp_if.sv
rtl/tts_slot_alu.sv
rtl/tick_task_scheduler_table_core.sv
tb/tick_task_scheduler_table_core_tb.sv
